// ===== design/mxe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mxe_pkg;

  // defaults for the top level parameters
  localparam int MAX_DIM_DEF    = 8;
  localparam int DATA_WIDTH_DEF = 32;

  // element format: signed Q16.16 in 32-bit words
  localparam int VAL_W  = 32;
  localparam int FRAC_W = 16;
  // sixteen full products at most, plus sign headroom
  localparam int ACC_W  = 2 * VAL_W + 8;

  // index fields and register file
  localparam int IDX_W   = 3;
  localparam int SIZE_W  = 4;
  localparam int MODE_W  = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [SIZE_W-1:0] SIZE_RST = 4'd8;

  // register index, taken from paddr[2]
  localparam logic REG_MATRIX_SIZE = 1'b0;

  // input item modes
  localparam logic [MODE_W-1:0] MODE_WR_A    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WR_B    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

  // control that travels with each multiply-accumulate term
  typedef struct packed {
    logic             valid;
    logic             first;  // clears the accumulator
    logic             last;   // closes one sum
    logic             prod;   // second pass, S * B^T
    logic             fin;    // final element of C
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mac_tag_t;

endpackage

`default_nettype wire

// ===== design/mxe_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mxe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/mxe_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mxe_seq #(
  parameter int MAX_DIM = mxe_pkg::MAX_DIM_DEF,
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [IW-1:0]    nm1_i,
  input  wire logic             out_free_i,
  input  wire logic             res_p2_i,
  input  wire logic             pipe_empty_i,
  output logic                  busy_o,
  output mxe_pkg::mac_tag_t     tag_o,
  output logic      [AW-1:0]    a_raddr_o,
  output logic      [AW-1:0]    b_raddr_o,
  output logic      [AW-1:0]    s_raddr_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SUM   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_PROD  = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;

  localparam logic [AW-1:0] DIM_A = AW'(MAX_DIM);

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, nm1_q, nm1_d;
  logic          t_q, t_d;
  logic          inflight_q, inflight_d;
  logic          issue;
  logic [AW-1:0] addr_ki, addr_kj, addr_ik, addr_jk;

  // cell addresses, row * MAX_DIM + col
  always_comb begin
    addr_ki = AW'(k_q) * DIM_A + AW'(i_q);
    addr_kj = AW'(k_q) * DIM_A + AW'(j_q);
    addr_ik = AW'(i_q) * DIM_A + AW'(k_q);
    addr_jk = AW'(j_q) * DIM_A + AW'(k_q);
  end

  // operand addresses for each term
  always_comb begin
    a_raddr_o = t_q ? addr_kj : addr_ki;
    s_raddr_o = addr_ik;
    if (state_q == ST_PROD) begin
      b_raddr_o = addr_jk;
    end else if (t_q) begin
      b_raddr_o = addr_ik;
    end else begin
      b_raddr_o = addr_kj;
    end
  end

  // loop counters and phase control
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    t_d     = t_q;
    nm1_d   = nm1_q;
    issue   = 1'b0;
    tag_o   = '0;
    tag_o.row = mxe_pkg::IDX_W'(i_q);
    tag_o.col = mxe_pkg::IDX_W'(j_q);
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SUM;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          t_d     = 1'b0;
          nm1_d   = nm1_i;
        end
      end
      ST_SUM: begin
        issue       = 1'b1;
        tag_o.valid = 1'b1;
        tag_o.first = !t_q && (k_q == '0);
        tag_o.last  = t_q && (k_q == j_q);
        if (!t_q) begin
          if (k_q == nm1_q) begin
            t_d = 1'b1;
            k_d = '0;
          end else begin
            k_d = k_q + 1'b1;
          end
        end else if (k_q == j_q) begin
          t_d = 1'b0;
          k_d = '0;
          if (j_q == nm1_q) begin
            j_d = '0;
            if (i_q == nm1_q) begin
              i_d     = '0;
              state_d = ST_DRAIN;
            end else begin
              i_d = i_q + 1'b1;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty_i) begin
          state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        // a new element starts only when its result has somewhere to go
        issue       = (k_q != '0) || (!inflight_q && out_free_i);
        tag_o.valid = issue;
        tag_o.prod  = 1'b1;
        tag_o.first = (k_q == '0);
        tag_o.last  = (k_q == nm1_q);
        tag_o.fin   = (i_q == nm1_q) && (j_q == nm1_q);
        if (issue) begin
          if (k_q == nm1_q) begin
            k_d = '0;
            if (j_q == nm1_q) begin
              j_d = '0;
              if (i_q == nm1_q) begin
                i_d     = '0;
                state_d = ST_WAIT;
              end else begin
                i_d = i_q + 1'b1;
              end
            end else begin
              j_d = j_q + 1'b1;
            end
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      ST_WAIT: begin
        if (!inflight_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // one product element in flight at a time
  always_comb begin
    inflight_d = inflight_q;
    if (res_p2_i) begin
      inflight_d = 1'b0;
    end
    if ((state_q == ST_PROD) && issue && (k_q == '0)) begin
      inflight_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      t_q        <= 1'b0;
      nm1_q      <= '0;
      inflight_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
      t_q        <= t_d;
      nm1_q      <= nm1_d;
      inflight_q <= inflight_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ===== design/mxe_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mxe_mac #(
  parameter int DATA_WIDTH = mxe_pkg::DATA_WIDTH_DEF,
  localparam int SAT_W = (DATA_WIDTH < mxe_pkg::VAL_W) ? DATA_WIDTH : mxe_pkg::VAL_W
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire mxe_pkg::mac_tag_t         tag_i,
  input  wire logic [mxe_pkg::VAL_W-1:0] a_i,
  input  wire logic [mxe_pkg::VAL_W-1:0] b_i,
  input  wire logic [mxe_pkg::VAL_W-1:0] s_i,
  output logic      [mxe_pkg::VAL_W-1:0] res_o,
  output mxe_pkg::mac_tag_t              res_tag_o,
  output logic                           empty_o
);

  localparam int VW = mxe_pkg::VAL_W;
  localparam int AW = mxe_pkg::ACC_W;
  localparam int SW = mxe_pkg::ACC_W - mxe_pkg::FRAC_W;

  localparam logic signed [SAT_W-1:0] SAT_MAX = {1'b0, {(SAT_W - 1){1'b1}}};
  localparam logic signed [SAT_W-1:0] SAT_MIN = {1'b1, {(SAT_W - 1){1'b0}}};

  mxe_pkg::mac_tag_t tag1_q, tag2_q, tag3_q;

  logic signed [VW-1:0]   x_op, y_op;
  logic signed [2*VW-1:0] prod_q;
  logic signed [AW-1:0]   acc_q, acc_base;
  logic signed [SW-1:0]   shifted;
  logic [SW-SAT_W:0]      upper;
  logic                   fits;
  logic signed [SAT_W-1:0] sat_val;

  // stage control follows the store read, the product and the sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  // operand select: A in the first pass, S in the second
  always_comb begin
    x_op = tag1_q.prod ? s_i : a_i;
    y_op = b_i;
  end

  // registered multiply
  always_ff @(posedge clk_i) begin
    prod_q <= (2 * VW)'(x_op) * (2 * VW)'(y_op);
  end

  // full width accumulate
  assign acc_base = tag2_q.first ? '0 : acc_q;

  always_ff @(posedge clk_i) begin
    if (tag2_q.valid) begin
      acc_q <= acc_base + AW'(prod_q);
    end
  end

  // drop the fraction bits (floor), then saturate
  always_comb begin
    shifted = acc_q[AW-1:mxe_pkg::FRAC_W];
    upper   = shifted[SW-1:SAT_W-1];
    fits    = (&upper) | ~(|upper);
    if (fits) begin
      sat_val = shifted[SAT_W-1:0];
    end else if (shifted[SW-1]) begin
      sat_val = SAT_MIN;
    end else begin
      sat_val = SAT_MAX;
    end
  end

  assign res_o     = VW'(sat_val);
  assign res_tag_o = tag3_q;
  assign empty_o   = !tag1_q.valid && !tag2_q.valid && !tag3_q.valid;

endmodule

`default_nettype wire

// ===== design/matrix_expr_at_b_plus_b_a_times_bt_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Matrix engine for C = (A^T*B + B*A) * B^T on N x N signed Q16.16 matrices, where in the
// B*A term A counts as upper triangular. Elements of A and B are loaded one transfer each
// (mode 0 and 1, taken back to back while idle); a mode 2 transfer starts the computation and the
// N*N elements of C come out in row-major order, last_o set on (N-1,N-1). N is the
// matrix_size register at address 0, clamped to 1..MAX_DIM. All work runs through one
// 32x32 multiplier and one wide accumulator that read one word per cycle from each of
// the A, B and intermediate stores. A compute item first forms the intermediate sum
// and then the elements of C, the latter stretched by any backpressure on the result
// channel. The block takes no input during that time.
// Stores are not cleared: every element used must be written first.

module matrix_expr_at_b_plus_b_a_times_bt_top #(
  parameter int MAX_DIM    = mxe_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = mxe_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mxe_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [mxe_pkg::PDATA_W-1:0]   pwdata,
  output logic      [mxe_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [mxe_pkg::MODE_W-1:0]    mode_i,
  input  wire logic [mxe_pkg::IDX_W-1:0]     row_i,
  input  wire logic [mxe_pkg::IDX_W-1:0]     col_i,
  input  wire logic signed [mxe_pkg::VAL_W-1:0] value_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [mxe_pkg::IDX_W-1:0]     out_row_o,
  output logic      [mxe_pkg::IDX_W-1:0]     out_col_o,
  output logic signed [mxe_pkg::VAL_W-1:0]   result_o,
  output logic                               last_o
);

  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int VW    = mxe_pkg::VAL_W;

  localparam logic [AW-1:0]               DIM_A = AW'(MAX_DIM);
  localparam logic [mxe_pkg::SIZE_W-1:0]  DIM_S = mxe_pkg::SIZE_W'(MAX_DIM);

  logic [mxe_pkg::SIZE_W-1:0] matrix_size_q;
  logic [mxe_pkg::SIZE_W-1:0] size_clamped;
  logic [IW-1:0]              nm1;

  logic          in_xfer, in_range, busy, start;
  logic          a_we, b_we, s_we;
  logic [AW-1:0] wr_addr, s_waddr;
  logic [AW-1:0] a_raddr, b_raddr, s_raddr;
  logic [VW-1:0] a_rdata, b_rdata, s_rdata;

  mxe_pkg::mac_tag_t issue_tag, res_tag;
  logic [VW-1:0]     res;
  logic              pipe_empty, res_p2, out_free;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_size_q <= mxe_pkg::SIZE_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == mxe_pkg::REG_MATRIX_SIZE)) begin
      matrix_size_q <= pwdata[mxe_pkg::SIZE_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mxe_pkg::REG_MATRIX_SIZE) ? mxe_pkg::PDATA_W'(matrix_size_q) : '0;

  // active size, clamped to 1..MAX_DIM
  always_comb begin
    if (matrix_size_q == '0) begin
      size_clamped = mxe_pkg::SIZE_W'(1);
    end else if (matrix_size_q > DIM_S) begin
      size_clamped = DIM_S;
    end else begin
      size_clamped = matrix_size_q;
    end
    nm1 = IW'(size_clamped - 1'b1);
  end

  // input transfers: element loads and compute start
  assign in_ready_o = !busy;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_range   = ({1'b0, row_i} < (mxe_pkg::IDX_W + 1)'(MAX_DIM)) &&
                      ({1'b0, col_i} < (mxe_pkg::IDX_W + 1)'(MAX_DIM));
  assign wr_addr    = AW'(row_i) * DIM_A + AW'(col_i);
  assign a_we       = in_xfer && in_range && (mode_i == mxe_pkg::MODE_WR_A);
  assign b_we       = in_xfer && in_range && (mode_i == mxe_pkg::MODE_WR_B);
  assign start      = in_xfer && (mode_i == mxe_pkg::MODE_COMPUTE);

  // intermediate sums go back to their own store
  assign s_we    = res_tag.valid && res_tag.last && !res_tag.prod;
  assign s_waddr = AW'(res_tag.row) * DIM_A + AW'(res_tag.col);
  assign res_p2  = res_tag.valid && res_tag.last && res_tag.prod;

  mxe_ram #(.WIDTH(VW), .DEPTH(CELLS)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (wr_addr),
    .wdata_i (value_i),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mxe_ram #(.WIDTH(VW), .DEPTH(CELLS)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (wr_addr),
    .wdata_i (value_i),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  mxe_ram #(.WIDTH(VW), .DEPTH(CELLS)) u_s_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (res),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  mxe_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .nm1_i        (nm1),
    .out_free_i   (out_free),
    .res_p2_i     (res_p2),
    .pipe_empty_i (pipe_empty),
    .busy_o       (busy),
    .tag_o        (issue_tag),
    .a_raddr_o    (a_raddr),
    .b_raddr_o    (b_raddr),
    .s_raddr_o    (s_raddr)
  );

  mxe_mac #(.DATA_WIDTH(DATA_WIDTH)) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (issue_tag),
    .a_i       (a_rdata),
    .b_i       (b_rdata),
    .s_i       (s_rdata),
    .res_o     (res),
    .res_tag_o (res_tag),
    .empty_o   (pipe_empty)
  );

  // result output register
  assign out_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (res_p2) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_p2) begin
      out_row_o <= res_tag.row;
      out_col_o <= res_tag.col;
      result_o  <= res;
      last_o    <= res_tag.fin;
    end
  end

endmodule

`default_nettype wire

// ===== design/mxe_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mxe_chk (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_o,
  input wire logic [mxe_pkg::MODE_W-1:0]        mode_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic [mxe_pkg::IDX_W-1:0]         out_row_o,
  input wire logic [mxe_pkg::IDX_W-1:0]         out_col_o,
  input wire logic signed [mxe_pkg::VAL_W-1:0]  result_o,
  input wire logic                              last_o
);

  // a compute transfer makes the block busy
  property p_busy_after_compute;
    @(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && in_ready_o && (mode_i == mxe_pkg::MODE_COMPUTE)) |=> !in_ready_o;
  endproperty
  a_busy_after_compute: assert property (p_busy_after_compute)
    else $error("input still ready after compute transfer");

  // a new result only shows up while a computation runs
  property p_result_from_compute;
    @(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_o) |-> $past(!in_ready_o);
  endproperty
  a_result_from_compute: assert property (p_result_from_compute)
    else $error("result appeared while block was idle");

  // the final element sits on the diagonal
  property p_last_on_diagonal;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && last_o) |-> (out_row_o == out_col_o);
  endproperty
  a_last_on_diagonal: assert property (p_last_on_diagonal)
    else $error("last element off the diagonal");

  // a stalled result holds
  property p_result_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(result_o) && $stable(last_o));
  endproperty
  a_result_hold: assert property (p_result_hold)
    else $error("stalled result changed");

endmodule

bind matrix_expr_at_b_plus_b_a_times_bt_top mxe_chk u_mxe_chk (.*);

`default_nettype wire

// ===== bench/mxe_result_checker.sv =====
`timescale 1ns / 1ps

// watches the load, result and register ports of the matrix engine, recomputes
// C = (A^T*B + B*A) * B^T on every compute transfer and compares each result transfer
module mxe_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // register port
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [mxe_pkg::PADDR_W-1:0]   paddr_i,
  input  logic [mxe_pkg::PDATA_W-1:0]   pwdata_i,
  // load channel
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [mxe_pkg::MODE_W-1:0]    mode_i,
  input  logic [mxe_pkg::IDX_W-1:0]     row_i,
  input  logic [mxe_pkg::IDX_W-1:0]     col_i,
  input  logic [mxe_pkg::VAL_W-1:0]     value_i,
  // result channel
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [mxe_pkg::IDX_W-1:0]     out_row_i,
  input  logic [mxe_pkg::IDX_W-1:0]     out_col_i,
  input  logic [mxe_pkg::VAL_W-1:0]     result_i,
  input  logic                          last_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import mxe_pkg::*;

  localparam int DIM = MAX_DIM_DEF;
  localparam int ACC_BITS = 80;
  localparam logic signed [ACC_BITS-1:0] Q_MAX = 80'sh7FFF_FFFF;
  localparam logic signed [ACC_BITS-1:0] Q_MIN = -80'sh8000_0000;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             last;
  } c_elem_t;

  logic [VAL_W-1:0]  a_mem [DIM*DIM];
  logic [VAL_W-1:0]  b_mem [DIM*DIM];
  logic [VAL_W-1:0]  s_mem [DIM*DIM];
  logic [SIZE_W-1:0] size_q;
  c_elem_t           c_expected [$];
  int                fails;

  // exact product of two q16.16 words
  function automatic logic signed [ACC_BITS-1:0] q_product(input logic [VAL_W-1:0] x,
                                                           input logic [VAL_W-1:0] y);
    logic signed [ACC_BITS-1:0] xs;
    logic signed [ACC_BITS-1:0] ys;
    xs = $signed(x);
    ys = $signed(y);
    return xs * ys;
  endfunction

  // drop 16 fraction bits (floor) and clip to 32 bits
  function automatic logic [VAL_W-1:0] q_floor_sat(input logic signed [ACC_BITS-1:0] acc);
    logic signed [ACC_BITS-1:0] q;
    q = acc >>> FRAC_W;
    if (q > Q_MAX) return 32'h7FFF_FFFF;
    if (q < Q_MIN) return 32'h8000_0000;
    return q[VAL_W-1:0];
  endfunction

  // intermediate sum into s_mem, then queue every element of C in row-major order
  task automatic form_expression();
    int n;
    int i;
    int j;
    int k;
    logic signed [ACC_BITS-1:0] acc;
    c_elem_t e;
    n = (size_q == 0) ? 1 : ((int'(size_q) > DIM) ? DIM : int'(size_q));
    for (i = 0; i < n; i++) begin
      for (j = 0; j < n; j++) begin
        acc = '0;
        for (k = 0; k < n; k++) acc += q_product(a_mem[k*DIM+i], b_mem[k*DIM+j]);
        // a counts as upper triangular in the b*a term
        for (k = 0; k <= j; k++) acc += q_product(b_mem[i*DIM+k], a_mem[k*DIM+j]);
        s_mem[i*DIM+j] = q_floor_sat(acc);
      end
    end
    for (i = 0; i < n; i++) begin
      for (j = 0; j < n; j++) begin
        acc = '0;
        for (k = 0; k < n; k++) acc += q_product(s_mem[i*DIM+k], b_mem[j*DIM+k]);
        e.row   = IDX_W'(i);
        e.col   = IDX_W'(j);
        e.value = q_floor_sat(acc);
        e.last  = (i == n - 1) && (j == n - 1);
        c_expected.push_back(e);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    c_elem_t want;
    if (!rst_ni) begin
      size_q = SIZE_RST;
      c_expected.delete();
      fails = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      // result transfer against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (c_expected.size() == 0) begin
          fails++;
          $display("%0t: unexpected result (%0d,%0d) %h last %b", $time,
                   out_row_i, out_col_i, result_i, last_i);
        end else begin
          want = c_expected.pop_front();
          if (out_row_i !== want.row) begin
            fails++;
            $display("%0t: out_row expected %0d actual %0d", $time, want.row, out_row_i);
          end
          if (out_col_i !== want.col) begin
            fails++;
            $display("%0t: out_col expected %0d actual %0d", $time, want.col, out_col_i);
          end
          if (result_i !== want.value) begin
            fails++;
            $display("%0t: result (%0d,%0d) expected %h actual %h", $time,
                     want.row, want.col, want.value, result_i);
          end
          if (last_i !== want.last) begin
            fails++;
            $display("%0t: last (%0d,%0d) expected %b actual %b", $time,
                     want.row, want.col, want.last, last_i);
          end
        end
      end

      // register write
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[2] == REG_MATRIX_SIZE)
        size_q = pwdata_i[SIZE_W-1:0];

      // load or compute transfer
      if (in_valid_i && in_ready_i) begin
        case (mode_i)
          MODE_WR_A:    a_mem[int'(row_i)*DIM + int'(col_i)] = value_i;
          MODE_WR_B:    b_mem[int'(row_i)*DIM + int'(col_i)] = value_i;
          MODE_COMPUTE: form_expression();
          default: ;
        endcase
      end

      pending_o <= c_expected.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== bench/tb_matrix_expr_at_b_plus_b_a_times_bt_top.sv =====
`timescale 1ns / 1ps

module tb_matrix_expr_at_b_plus_b_a_times_bt_top;
  import mxe_pkg::*;

  localparam int DIM           = MAX_DIM_DEF;
  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 16;
  localparam int ITEM_TARGET   = 370;

  // mode with no function, the block drops it
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [MODE_W-1:0]   mode_i = MODE_WR_A;
  logic [IDX_W-1:0]    row_i = '0;
  logic [IDX_W-1:0]    col_i = '0;
  logic [VAL_W-1:0]    value_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [IDX_W-1:0]    out_row_o;
  logic [IDX_W-1:0]    out_col_o;
  logic [VAL_W-1:0]    result_o;
  logic                last_o;

  int                  fail_count;
  int                  pending;
  int                  send_idle_pct = 9;
  int                  recv_idle_pct = 70;
  int                  stall_cycles = 0;
  int                  items_sent = 0;
  logic [SIZE_W-1:0]   size_now = SIZE_RST;
  bit                  a_loaded [DIM*DIM];
  bit                  b_loaded [DIM*DIM];

  matrix_expr_at_b_plus_b_a_times_bt_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .result_o    (result_o),
    .last_o      (last_o)
  );

  mxe_result_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .mode_i       (mode_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .value_i      (value_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_row_i    (out_row_o),
    .out_col_i    (out_col_o),
    .result_i     (result_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // random backpressure on the result channel
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // element value: mostly small q16.16, some full range and corner words
  function automatic logic [VAL_W-1:0] pick_value();
    int sel;
    int v;
    sel = $urandom_range(99);
    if (sel < 10) begin
      case ($urandom_range(3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (sel < 30) return $urandom();
    if (sel < 55) begin
      v = $urandom_range(1 << 24) - (1 << 23);
      return v;
    end
    v = $urandom_range(1 << 18) - (1 << 17);
    return v;
  endfunction

  // one transfer on the load channel, with random gaps ahead of it
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    row_i      <= row;
    col_i      <= col;
    value_i    <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (mode == MODE_WR_A) a_loaded[int'(row)*DIM + int'(col)] = 1'b1;
    if (mode == MODE_WR_B) b_loaded[int'(row)*DIM + int'(col)] = 1'b1;
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  // fill every element of the n x n corner not yet loaded in this job
  task automatic load_missing(input int n);
    int r;
    int c;
    for (r = 0; r < n; r++)
      for (c = 0; c < n; c++)
        if (!a_loaded[r*DIM+c]) send_item(MODE_WR_A, IDX_W'(r), IDX_W'(c), pick_value());
    for (r = 0; r < n; r++)
      for (c = 0; c < n; c++)
        if (!b_loaded[r*DIM+c]) send_item(MODE_WR_B, IDX_W'(r), IDX_W'(c), pick_value());
  endtask

  // hold the load channel until every result is out and the block has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write: setup then access cycle, only while idle
  task automatic set_size(input logic [SIZE_W-1:0] size_val);
    logic [PDATA_W-1:0] w;
    drain();
    w = $urandom();
    w[SIZE_W-1:0] = size_val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MATRIX_SIZE, 2'b00};
    pwdata  <= w;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    size_now = size_val;
  endtask

  initial begin
    int n;
    int writes;
    int pick;
    bit wide_done;
    logic [SIZE_W-1:0] size_val;
    wide_done = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // size zero acts as one: positive then negative saturation
    set_size(4'd0);
    send_item(MODE_WR_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
    send_item(MODE_WR_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
    send_item(MODE_COMPUTE, 3'd0, 3'd0, 32'h0000_0000);
    send_item(MODE_WR_A, 3'd0, 3'd0, 32'h8000_0000);
    send_item(MODE_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);
    send_item(MODE_COMPUTE, 3'd7, 3'd7, 32'h1234_5678);
    // elements beyond n are kept but unused
    send_item(MODE_WR_A, 3'd7, 3'd7, 32'h0001_0000);
    send_item(MODE_WR_B, 3'd7, 3'd0, 32'hFFFF_FFFF);
    // small 2 x 2 case with corner words
    set_size(4'd2);
    send_item(MODE_WR_A, 3'd0, 3'd1, 32'h8000_0000);
    send_item(MODE_WR_B, 3'd1, 3'd0, 32'h0000_8000);
    load_missing(2);
    send_item(MODE_COMPUTE, 3'd0, 3'd0, 32'h0000_0000);

    // random jobs: load a and b, then one compute transfer
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent >= ITEM_TARGET / 3) begin
        send_idle_pct = 70;
        recv_idle_pct = 9;
      end

      pick = $urandom_range(99);
      if (!wide_done && items_sent >= 2 * ITEM_TARGET / 3) size_val = 4'd15;
      else if (pick < 35) size_val = size_now;
      else if (pick < 75) size_val = SIZE_W'($urandom_range(1, 3));
      else if (pick < 90) size_val = SIZE_W'($urandom_range(4, 5));
      else if (pick < 95) size_val = SIZE_W'($urandom_range(6, 8));
      else size_val = SIZE_W'($urandom_range(9, 15));
      if (int'(size_val) > DIM) wide_done = 1'b1;
      if (size_val != size_now) set_size(size_val);
      n = (size_now == 0) ? 1 : ((int'(size_now) > DIM) ? DIM : int'(size_now));

      foreach (a_loaded[i]) begin
        a_loaded[i] = 1'b0;
        b_loaded[i] = 1'b0;
      end
      writes = $urandom_range(n * n);
      repeat (writes) begin
        pick = $urandom_range(99);
        if (pick < 5)
          send_item(MODE_UNUSED, IDX_W'($urandom()), IDX_W'($urandom()), $urandom());
        else if (pick < 12)
          send_item(pick[0] ? MODE_WR_B : MODE_WR_A, IDX_W'($urandom_range(DIM - 1)),
                    IDX_W'($urandom_range(DIM - 1)), pick_value());
        else
          send_item(pick[0] ? MODE_WR_B : MODE_WR_A, IDX_W'($urandom_range(n - 1)),
                    IDX_W'($urandom_range(n - 1)), pick_value());
      end
      load_missing(n);
      send_item(MODE_COMPUTE, IDX_W'($urandom()), IDX_W'($urandom()), $urandom());
    end

    drain();
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
